/* hdl/node_presence_aging_table_top_assert.svh */
// assertion macros for the presence table
`ifndef NODE_PRESENCE_AGING_TABLE_TOP_ASSERT_SVH
`define NODE_PRESENCE_AGING_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define NPAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition must never be seen outside reset
`define NPAT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define NPAT_ASSERT(lbl, prop, msg)
`define NPAT_NEVER(lbl, cond, msg)
`endif
`endif

/* hdl/npat_pkg.sv */
// shared types and constants of the presence table
`default_nettype none
package npat_pkg;

   localparam int TYPE_W    = 8;
   localparam int ADDR_W    = 11;
   localparam int AGE_W     = 4;
   localparam int CNT_OUT_W = 5;
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;

   localparam logic [AGE_W-1:0]     AGE_MAX   = 4'd15;
   localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 5'd31;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_AGE_LIMIT = 2'd0;
   localparam logic [1:0] REG_TYPE_A    = 2'd1;
   localparam logic [1:0] REG_TYPE_B    = 2'd2;
   localparam logic [1:0] REG_TYPE_C    = 2'd3;

   // req_type codes
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [AGE_W-1:0]  AGE_LIMIT_RST = 4'd4;
   localparam logic [TYPE_W-1:0] TYPE_A_RST    = 8'd0;
   localparam logic [TYPE_W-1:0] TYPE_B_RST    = 8'd1;
   localparam logic [TYPE_W-1:0] TYPE_C_RST    = 8'd2;

   typedef struct packed {
      logic [TYPE_W-1:0] node_type;
      logic [ADDR_W-1:0] node_address;
      logic [AGE_W-1:0]  age;
   } entry_type;

   // one write command to the table
   typedef struct packed {
      logic      wr_data;
      logic      set_valid;
      logic      clr_valid;
      entry_type entry;
   } tbl_wr_type;

endpackage
`default_nettype wire

/* hdl/npat_table.sv */
// entry memory with per-entry valid bits, one read and one write port
`default_nettype none
module npat_table #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output npat_pkg::entry_type        rd_entry,
   output logic                       rd_valid,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire npat_pkg::tbl_wr_type  wr_cmd
);

   npat_pkg::entry_type mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   npat_pkg::entry_type rd_entry_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_cmd.wr_data) begin
         mem[wr_addr] <= wr_cmd.entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_cmd.set_valid) begin
            valid_ff[wr_addr] <= 1'b1;
         end else if (wr_cmd.clr_valid) begin
            valid_ff[wr_addr] <= 1'b0;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

/* hdl/node_presence_aging_table_top.sv */
// presence table with aging: top level, sequencer and register port
// a known frame or a tick scans the whole table before its result is loaded, a known frame
// then writes its entry in a finish step; a frame of an unknown type code skips the scan
// throughput: one item at a time, the next item is taken only once the previous result has
// moved into the result register; the scan walks one entry per cycle over the single read port
// reset: synchronous, active high; table empty, registers to defaults, no result pending
`default_nettype none
`include "node_presence_aging_table_top_assert.svh"
module node_presence_aging_table_top #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input items
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [23:0]                   req_tdata,  // node_type[7:0], node_address[18:8]
   input  wire logic                          req_tuser,  // req_type: 0 frame, 1 tick
   // result items
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [15:0]                        rsp_tdata,  // refreshed[0], added[1],
                                                          // dropped_full[2], removed_count[7:3],
                                                          // poll_request[8], entry_count[13:9]
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [npat_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [npat_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [npat_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = ($clog2(TABLE_ENTRIES + 1) > npat_pkg::CNT_OUT_W) ?
                          $clog2(TABLE_ENTRIES + 1) : npat_pkg::CNT_OUT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_DONE
   } state_type;

   // ---------------------------------------------------------------- registers
   logic [npat_pkg::AGE_W-1:0]  age_limit_ff;
   logic [npat_pkg::TYPE_W-1:0] type_a_ff, type_b_ff, type_c_ff;
   logic csr_we;

   assign csr_we     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= npat_pkg::AGE_LIMIT_RST;
         type_a_ff    <= npat_pkg::TYPE_A_RST;
         type_b_ff    <= npat_pkg::TYPE_B_RST;
         type_c_ff    <= npat_pkg::TYPE_C_RST;
      end else if (csr_we) begin
         case (csr_paddr[3:2])
            npat_pkg::REG_AGE_LIMIT: age_limit_ff <= csr_pwdata[npat_pkg::AGE_W-1:0];
            npat_pkg::REG_TYPE_A:    type_a_ff    <= csr_pwdata[npat_pkg::TYPE_W-1:0];
            npat_pkg::REG_TYPE_B:    type_b_ff    <= csr_pwdata[npat_pkg::TYPE_W-1:0];
            npat_pkg::REG_TYPE_C:    type_c_ff    <= csr_pwdata[npat_pkg::TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         npat_pkg::REG_AGE_LIMIT: csr_prdata = npat_pkg::CSR_DW'(age_limit_ff);
         npat_pkg::REG_TYPE_A:    csr_prdata = npat_pkg::CSR_DW'(type_a_ff);
         npat_pkg::REG_TYPE_B:    csr_prdata = npat_pkg::CSR_DW'(type_b_ff);
         npat_pkg::REG_TYPE_C:    csr_prdata = npat_pkg::CSR_DW'(type_c_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- sequencer state
   state_type state_ff, state_in;
   logic                         kind_ff, kind_in;
   logic [npat_pkg::TYPE_W-1:0]  ntype_ff, ntype_in;
   logic [npat_pkg::ADDR_W-1:0]  naddr_ff, naddr_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_done_ff, rd_done_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic res_refreshed_ff, res_refreshed_in;
   logic res_added_ff, res_added_in;
   logic res_dropped_ff, res_dropped_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_refreshed_ff, rsp_refreshed_in;
   logic rsp_added_ff, rsp_added_in;
   logic rsp_dropped_ff, rsp_dropped_in;
   logic rsp_poll_ff, rsp_poll_in;
   logic [npat_pkg::CNT_OUT_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [npat_pkg::CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   // table interface
   npat_pkg::entry_type  tbl_rd_entry;
   logic                 tbl_rd_valid;
   npat_pkg::tbl_wr_type tbl_wr;
   logic [IDX_W-1:0]     tbl_wr_addr;

   logic req_accept;
   logic known_code;
   logic entry_match;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;

   // a frame only counts when its type is one of the three codes
   assign known_code = (req_tdata[7:0] == type_a_ff) || (req_tdata[7:0] == type_b_ff) ||
                       (req_tdata[7:0] == type_c_ff);

   assign entry_match = tbl_rd_valid && (tbl_rd_entry.node_type == ntype_ff) &&
                        (tbl_rd_entry.node_address == naddr_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;

   npat_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_idx_ff),
      .rd_entry (tbl_rd_entry),
      .rd_valid (tbl_rd_valid),
      .wr_addr  (tbl_wr_addr),
      .wr_cmd   (tbl_wr)
   );

   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      ntype_in         = ntype_ff;
      naddr_in         = naddr_ff;
      rd_idx_in        = rd_idx_ff;
      rd_done_in       = rd_done_ff;
      cmp_vld_in       = 1'b0;
      cmp_idx_in       = cmp_idx_ff;
      hit_in           = hit_ff;
      hit_idx_in       = hit_idx_ff;
      free_in          = free_ff;
      free_idx_in      = free_idx_ff;
      count_in         = count_ff;
      removed_in       = removed_ff;
      res_refreshed_in = res_refreshed_ff;
      res_added_in     = res_added_ff;
      res_dropped_in   = res_dropped_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_tready;
      rsp_refreshed_in = rsp_refreshed_ff;
      rsp_added_in     = rsp_added_ff;
      rsp_dropped_in   = rsp_dropped_ff;
      rsp_poll_in      = rsp_poll_ff;
      rsp_removed_in   = rsp_removed_ff;
      rsp_count_in     = rsp_count_ff;
      tbl_wr           = '0;
      tbl_wr_addr      = cmp_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in          = req_tuser;
               ntype_in         = req_tdata[7:0];
               naddr_in         = req_tdata[18:8];
               rd_idx_in        = '0;
               rd_done_in       = 1'b0;
               hit_in           = 1'b0;
               free_in          = 1'b0;
               removed_in       = '0;
               res_refreshed_in = 1'b0;
               res_added_in     = 1'b0;
               res_dropped_in   = 1'b0;
               // a frame of an unknown type code leaves the table alone
               state_in = (req_tuser || known_code) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            // issue stage: one memory read per cycle
            if (!rd_done_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
               if (rd_idx_ff == LAST_IDX) begin
                  rd_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            // compare stage: data of the entry read in the previous cycle
            if (cmp_vld_ff) begin
               if (kind_ff) begin
                  if (tbl_rd_valid) begin
                     if (tbl_rd_entry.age > age_limit_ff) begin
                        tbl_wr.clr_valid = 1'b1;
                        removed_in       = removed_ff + CNT_W'(1);
                        count_in         = count_ff - CNT_W'(1);
                     end else if (tbl_rd_entry.age < npat_pkg::AGE_MAX) begin
                        tbl_wr.wr_data   = 1'b1;
                        tbl_wr.entry     = tbl_rd_entry;
                        tbl_wr.entry.age = tbl_rd_entry.age + npat_pkg::AGE_W'(1);
                     end
                  end
               end else begin
                  // keep the first match and the lowest free slot
                  if (entry_match && !hit_ff) begin
                     hit_in     = 1'b1;
                     hit_idx_in = cmp_idx_ff;
                  end
                  if (!tbl_rd_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
               end
               if (cmp_idx_ff == LAST_IDX) begin
                  state_in = kind_ff ? ST_DONE : ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            tbl_wr.entry.node_type    = ntype_ff;
            tbl_wr.entry.node_address = naddr_ff;
            tbl_wr.entry.age          = '0;
            if (hit_ff) begin
               tbl_wr.wr_data   = 1'b1;
               tbl_wr_addr      = hit_idx_ff;
               res_refreshed_in = 1'b1;
            end else if (free_ff) begin
               tbl_wr.wr_data   = 1'b1;
               tbl_wr.set_valid = 1'b1;
               tbl_wr_addr      = free_idx_ff;
               count_in         = count_ff + CNT_W'(1);
               res_added_in     = 1'b1;
            end else begin
               res_dropped_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the result register is free
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_refreshed_in = res_refreshed_ff;
               rsp_added_in     = res_added_ff;
               rsp_dropped_in   = res_dropped_ff;
               rsp_poll_in      = kind_ff;
               rsp_removed_in   = (removed_ff > CNT_W'(npat_pkg::COUNT_MAX)) ?
                                  npat_pkg::COUNT_MAX : removed_ff[npat_pkg::CNT_OUT_W-1:0];
               rsp_count_in     = (count_ff > CNT_W'(npat_pkg::COUNT_MAX)) ?
                                  npat_pkg::COUNT_MAX : count_ff[npat_pkg::CNT_OUT_W-1:0];
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // payload and per-item scratch, no reset needed
      kind_ff          <= kind_in;
      ntype_ff         <= ntype_in;
      naddr_ff         <= naddr_in;
      rd_idx_ff        <= rd_idx_in;
      cmp_idx_ff       <= cmp_idx_in;
      hit_ff           <= hit_in;
      hit_idx_ff       <= hit_idx_in;
      free_ff          <= free_in;
      free_idx_ff      <= free_idx_in;
      removed_ff       <= removed_in;
      res_refreshed_ff <= res_refreshed_in;
      res_added_ff     <= res_added_in;
      res_dropped_ff   <= res_dropped_in;
      rsp_refreshed_ff <= rsp_refreshed_in;
      rsp_added_ff     <= rsp_added_in;
      rsp_dropped_ff   <= rsp_dropped_in;
      rsp_poll_ff      <= rsp_poll_in;
      rsp_removed_ff   <= rsp_removed_in;
      rsp_count_ff     <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_done_ff   <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_done_ff   <= rd_done_in;
         cmp_vld_ff   <= cmp_vld_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_poll_ff, rsp_removed_ff,
                        rsp_dropped_ff, rsp_added_ff, rsp_refreshed_ff};

   // ---------------------------------------------------------------- checks
   // at most one outcome flag per item, tick counts as one
   `NPAT_ASSERT(a_one_outcome, rsp_valid_ff |-> $onehot0({rsp_refreshed_ff, rsp_added_ff, rsp_dropped_ff, rsp_poll_ff}), "more than one outcome flag set")
   // occupancy never beyond table size
   `NPAT_NEVER(a_count_bound, count_ff > CNT_W'(TABLE_ENTRIES), "entry count exceeds table size")
   // removals only reported on ticks
   `NPAT_NEVER(a_removed_on_frame, rsp_valid_ff && !rsp_poll_ff && (rsp_removed_ff != '0), "removal reported on a frame")
   // table is never written while idle
   `NPAT_NEVER(a_no_idle_write, (state_ff == ST_IDLE) && (tbl_wr.wr_data || tbl_wr.set_valid || tbl_wr.clr_valid), "table written while idle")

endmodule
`default_nettype wire

/* tb/presence_scoreboard.sv */
// scoreboard for the presence table: snoops both channels and the register port, predicts, compares
`timescale 1ns / 100ps
module presence_scoreboard #(
   parameter int ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [23:0]                     req_tdata,   // node_type[7:0], node_address[18:8]
   input  logic                            req_tuser,   // req_type
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [15:0]                     rsp_tdata,   // refreshed, added, dropped_full,
                                                        // removed_count, poll_request, entry_count
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [npat_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [npat_pkg::CSR_DW-1:0]     csr_pwdata,
   input  logic [npat_pkg::CSR_DW-1:0]     csr_prdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              pending,
   output int                              n_results,
   output int                              n_refreshed,
   output int                              n_added,
   output int                              n_dropped,
   output int                              n_removed
);
   import npat_pkg::*;

   // members listed from the highest bit down, matching rsp_tdata[13:0]
   typedef struct packed {
      logic [CNT_OUT_W-1:0] entry_count;
      logic                 poll_request;
      logic [CNT_OUT_W-1:0] removed_count;
      logic                 dropped_full;
      logic                 added;
      logic                 refreshed;
   } presence_result_type;

   logic              slot_valid [ENTRIES];
   logic [TYPE_W-1:0] slot_type  [ENTRIES];
   logic [ADDR_W-1:0] slot_addr  [ENTRIES];
   logic [AGE_W-1:0]  slot_age   [ENTRIES];
   logic [7:0]        csr_shadow [4];
   presence_result_type awaited_results [$];

   function automatic logic [CNT_OUT_W-1:0] saturate(int n);
      return (n > int'(COUNT_MAX)) ? COUNT_MAX : CNT_OUT_W'(n);
   endfunction

   function automatic string describe(presence_result_type r);
      return $sformatf("ref=%0d add=%0d drop=%0d removed=%0d poll=%0d count=%0d",
                       r.refreshed, r.added, r.dropped_full, r.removed_count,
                       r.poll_request, r.entry_count);
   endfunction

   // applies one item to the table copy and returns what the block must answer
   function automatic presence_result_type predict_presence(logic kind,
                                                            logic [TYPE_W-1:0] ntype,
                                                            logic [ADDR_W-1:0] naddr);
      presence_result_type r;
      logic [AGE_W-1:0] limit;
      int removed;
      int live;
      int hit;
      int free_slot;
      r = '0;
      limit = csr_shadow[REG_AGE_LIMIT][AGE_W-1:0];
      removed = 0;
      live = 0;
      hit = -1;
      free_slot = -1;
      if (kind == KIND_TICK) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
               if (slot_age[i] > limit) begin
                  slot_valid[i] = 1'b0;
                  removed++;
               end else if (slot_age[i] != AGE_MAX) begin
                  slot_age[i] = slot_age[i] + 1'b1;
               end
            end
         end
         r.poll_request = 1'b1;
      end else if (ntype == csr_shadow[REG_TYPE_A] || ntype == csr_shadow[REG_TYPE_B] ||
                   ntype == csr_shadow[REG_TYPE_C]) begin
         // walk downward so the lowest matching or free slot wins
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (slot_valid[i] && slot_type[i] == ntype && slot_addr[i] == naddr) hit = i;
            if (!slot_valid[i]) free_slot = i;
         end
         if (hit >= 0) begin
            slot_age[hit] = '0;
            r.refreshed = 1'b1;
         end else if (free_slot >= 0) begin
            slot_valid[free_slot] = 1'b1;
            slot_type[free_slot] = ntype;
            slot_addr[free_slot] = naddr;
            slot_age[free_slot] = '0;
            r.added = 1'b1;
         end else begin
            r.dropped_full = 1'b1;
         end
      end
      for (int i = 0; i < ENTRIES; i++) if (slot_valid[i]) live++;
      r.removed_count = saturate(removed);
      r.entry_count = saturate(live);
      return r;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("presence_scoreboard: %s", msg);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      presence_result_type got;
      presence_result_type want;
      logic [1:0] idx;
      idx = csr_paddr[3:2];
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_type[i] = '0;
            slot_addr[i] = '0;
            slot_age[i] = '0;
         end
         csr_shadow[REG_AGE_LIMIT] = 8'(AGE_LIMIT_RST);
         csr_shadow[REG_TYPE_A] = TYPE_A_RST;
         csr_shadow[REG_TYPE_B] = TYPE_B_RST;
         csr_shadow[REG_TYPE_C] = TYPE_C_RST;
         awaited_results.delete();
         n_results = 0;
         n_refreshed = 0;
         n_added = 0;
         n_dropped = 0;
         n_removed = 0;
      end else begin
         // register access phase
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               csr_shadow[idx] = (idx == REG_AGE_LIMIT) ? {4'b0, csr_pwdata[AGE_W-1:0]}
                                                        : csr_pwdata[7:0];
            end else if (csr_prdata != CSR_DW'(csr_shadow[idx])) begin
               note_failure($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                      idx, csr_prdata, csr_shadow[idx]));
            end
         end
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = presence_result_type'(rsp_tdata[13:0]);
            n_results++;
            if (awaited_results.size() == 0) begin
               note_failure($sformatf("result with nothing awaited: %s", describe(got)));
            end else begin
               want = awaited_results.pop_front();
               if (got.refreshed != want.refreshed || got.added != want.added ||
                   got.dropped_full != want.dropped_full ||
                   got.removed_count != want.removed_count ||
                   got.poll_request != want.poll_request ||
                   got.entry_count != want.entry_count || rsp_tdata[15:14] != 2'b00) begin
                  note_failure($sformatf("result %0d expected %s, got %s (pad %b)", n_results,
                                         describe(want), describe(got), rsp_tdata[15:14]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_presence(req_tuser, req_tdata[7:0], req_tdata[18:8]);
            n_refreshed += int'(want.refreshed);
            n_added += int'(want.added);
            n_dropped += int'(want.dropped_full);
            n_removed += int'(want.removed_count);
            awaited_results.push_back(want);
         end
      end
      pending = awaited_results.size();
   end

endmodule

/* tb/tb.sv */
// top of the presence table testbench: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps
module tb;
   import npat_pkg::*;

   localparam int ENTRIES      = 16;
   // length of the closing wait, reckoned from the table size
   localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 216;
   localparam int HOLD_CYCLES  = 400;
   // longest correct quiet stretch is the receiver hold plus one scan; random stalls are short
   localparam int QUIET_LIMIT  = 5000;
   localparam int POOL_DEPTH   = 40;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;     // node_type[7:0], node_address[18:8]
   logic                req_tuser   = 1'b0;   // req_type: 0 frame, 1 tick
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [15:0]         rsp_tdata;            // refreshed[0], added[1], dropped_full[2],
                                              // removed_count[7:3], poll_request[8],
                                              // entry_count[13:9]
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int fail_count;
   int pending;
   int n_results;
   int n_refreshed;
   int n_added;
   int n_dropped;
   int n_removed;

   // idling controls: percent of cycles the sender idles and the receiver stalls
   int   send_idle     = 0;
   int   stall_pct     = 0;
   logic hold_request  = 1'b0;
   logic hold_done     = 1'b0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;
   int   items_sent    = 0;
   int   settings_used = 1;

   // type codes currently loaded, so frames can aim at known types
   logic [TYPE_W-1:0] code_a = TYPE_A_RST;
   logic [TYPE_W-1:0] code_b = TYPE_B_RST;
   logic [TYPE_W-1:0] code_c = TYPE_C_RST;

   always #1 clock = ~clock;

   node_presence_aging_table_top #(
      .TABLE_ENTRIES(ENTRIES)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   presence_scoreboard #(
      .ENTRIES(ENTRIES)
   ) i_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending),
      .n_results   (n_results),
      .n_refreshed (n_refreshed),
      .n_added     (n_added),
      .n_dropped   (n_dropped),
      .n_removed   (n_removed)
   );

   // result side: random stalls, plus one long hold-off counted here so the block backs up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog: ends the run after too many cycles with nothing accepted anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one register access: setup cycle, access cycle, then an idle cycle (pready always high)
   task automatic csr_access(logic is_write, logic [1:0] idx, logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      // upper bits are noise the register must ignore
      csr_pwdata <= ($urandom() & 32'hFFFF_FF00) | CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // write all four registers, then read each one back
   task automatic load_config(logic [AGE_W-1:0] limit, logic [TYPE_W-1:0] ca,
                              logic [TYPE_W-1:0] cb, logic [TYPE_W-1:0] cc);
      csr_access(1'b1, REG_AGE_LIMIT, {4'b0, limit});
      csr_access(1'b1, REG_TYPE_A, ca);
      csr_access(1'b1, REG_TYPE_B, cb);
      csr_access(1'b1, REG_TYPE_C, cc);
      for (int r = REG_AGE_LIMIT; r <= REG_TYPE_C; r++) csr_access(1'b0, 2'(r), 8'h00);
      code_a = ca;
      code_b = cb;
      code_c = cc;
      settings_used++;
   endtask

   // offer one item and hold it until the block takes it; returns at a falling edge
   task automatic send_item(logic kind, logic [TYPE_W-1:0] ntype, logic [ADDR_W-1:0] naddr);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'b0, naddr, ntype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every awaited result has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // random traffic: frames mostly from a small address pool with the loaded type codes,
   // so entries get refreshed, the table fills and ages run out; the rest is noise
   task automatic run_phase(int count, int tick_pct, int pool_size, logic with_hold);
      logic [ADDR_W-1:0] pool [POOL_DEPTH];
      logic [TYPE_W-1:0] ntype;
      logic [ADDR_W-1:0] naddr;
      int pick;
      for (int i = 0; i < POOL_DEPTH; i++) pool[i] = ADDR_W'($urandom());
      pool[0] = '0;
      pool[1] = '1;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 4) hold_request <= 1'b1;
         if ($urandom_range(99) < tick_pct) begin
            // node fields of a tick are ignored, so fill them with noise
            send_item(KIND_TICK, TYPE_W'($urandom()), ADDR_W'($urandom()));
         end else begin
            pick = $urandom_range(19);
            if (pick < 6) ntype = code_a;
            else if (pick < 12) ntype = code_b;
            else if (pick < 17) ntype = code_c;
            else ntype = TYPE_W'($urandom());
            if ($urandom_range(99) < 85) naddr = pool[$urandom_range(pool_size - 1)];
            else naddr = ADDR_W'($urandom_range(2047));
            send_item(KIND_FRAME, ntype, naddr);
         end
      end
   endtask

   initial begin
      logic [AGE_W-1:0]  lim;
      logic [TYPE_W-1:0] ca;
      logic [TYPE_W-1:0] cb;
      logic [TYPE_W-1:0] cc;
      int tick_pct;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset settings: age limit 4, codes 0, 1, 2
      send_item(KIND_FRAME, 8'h00, 11'h000);    // new node in the lowest slot
      send_item(KIND_FRAME, 8'h00, 11'h000);    // same node again, age cleared
      send_item(KIND_FRAME, 8'hFF, 11'h7FF);    // unknown type code, nothing changes
      send_item(KIND_FRAME, 8'h02, 11'h7FF);
      send_item(KIND_FRAME, 8'h01, 11'h4D2);
      send_item(KIND_TICK, 8'hFF, 11'h7FF);     // tick with noise in the ignored fields
      drain();

      // equal codes, age limit 0: type 0 becomes unknown though still stored
      load_config(4'd0, 8'hFF, 8'hFF, 8'h07);
      send_item(KIND_FRAME, 8'hFF, 11'h7FF);
      send_item(KIND_FRAME, 8'h00, 11'h000);
      for (int i = 0; i < 12; i++) send_item(KIND_FRAME, 8'h07, ADDR_W'(16 + i));
      send_item(KIND_FRAME, 8'h07, 11'h555);    // table full, node dropped
      // first tick removes three neighboring old entries, second removes all the rest
      send_item(KIND_TICK, 8'h00, 11'h000);
      send_item(KIND_TICK, 8'h00, 11'h000);

      // random phases, each under fresh settings and its own idling mix
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == 0) lim = 4'd15;               // nothing ever removed, ages saturate
         else if (p == 1) lim = 4'd0;
         else if (p == 2) lim = 4'd14;
         else lim = AGE_W'($urandom_range(15));
         if (p == 1) begin
            ca = 8'h00;
            cb = 8'h00;
            cc = 8'hFF;
         end else begin
            ca = TYPE_W'($urandom());
            cb = ($urandom_range(4) == 0) ? ca : TYPE_W'($urandom());
            cc = ($urandom_range(4) == 0) ? cb : TYPE_W'($urandom());
         end
         load_config(lim, ca, cb, cc);
         tick_pct = (p == 0) ? 45 : $urandom_range(8, 30);
         case (p % 4)
            0: begin
               send_idle = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle = 74;
               stall_pct <= 0;
            end
            2: begin
               send_idle = 0;
               stall_pct <= 74;
            end
            default: begin
               send_idle = 23;
               stall_pct <= 23;
            end
         endcase
         // the long receiver hold-off falls in a phase where the sender never idles
         run_phase(PHASE_ITEMS, tick_pct, $urandom_range(4, POOL_DEPTH), p == 4);
      end

      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("tb: %0d items under %0d register settings, %0d results compared",
               items_sent, settings_used, n_results);
      $display("tb: predicted %0d refreshes, %0d new entries, %0d drops, %0d aged out",
               n_refreshed, n_added, n_dropped, n_removed);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/npat_pkg.sv
hdl/npat_table.sv
hdl/node_presence_aging_table_top.sv
tb/presence_scoreboard.sv
tb/tb.sv
